[rtl/sql_quoted_literal_masker_core_assert.svh]
// Assertion macros shared by the masker RTL.
`ifndef SQL_QUOTED_LITERAL_MASKER_CORE_ASSERT_SVH
`define SQL_QUOTED_LITERAL_MASKER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SQLM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define SQLM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/sqlm_pkg.sv]
package sqlm_pkg;

  localparam logic [7:0] CH_MASK   = 8'h3F;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef enum logic [1:0] {
    REGION_OUT     = 2'd0,
    REGION_IN      = 2'd1,
    REGION_CLOSING = 2'd2
  } region_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_keep;
    logic       out_last;
  } out_t;

endpackage

[rtl/sql_quoted_literal_masker_core.sv]
// Query literal masker. Query text enters one byte per transaction on the
// input channel (in_valid_i / in_stall_o / in_i); in_last marks the final
// byte of a query. Every accepted byte yields exactly one result transaction
// on the output channel (out_valid_o / out_stall_i / out_o): the opening
// quote of a literal comes out as '?', the rest of the literal and its
// closing quote come out with out_keep low and a zero byte, and all other
// bytes pass through with out_keep high. out_last copies in_last.
// Path: a byte accepted on the input channel is loaded into the input register,
// and its result is then registered in the result register, which shows it
// until the receiver takes it; a stall can hold the byte in the input register.
// Throughput: one byte per cycle unless the receiver stalls; the scan state
// (region, quote kind, escape flag) updates per byte between the registers.
// Reset clears both stage valids and returns the scan to outside a literal;
// the state also returns there after each byte with in_last set.
// When the receiver stalls, the result register holds its transaction, the
// input register holds one more byte, and then in_stall_o rises.
`include "sql_quoted_literal_masker_core_assert.svh"

module sql_quoted_literal_masker_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  sqlm_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output sqlm_pkg::out_t out_o
);

  logic           in_valid_q;
  sqlm_pkg::in_t  in_q;
  sqlm_pkg::out_t result;
  logic           out_busy;
  logic           advance;

  // Move the held byte forward whenever the result register can take it.
  assign advance = in_valid_q && !out_busy;

  sqlm_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .advance_i  (advance),
    .valid_o    (in_valid_q),
    .data_o     (in_q)
  );

  sqlm_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (in_q),
    .result_o  (result)
  );

  sqlm_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .result_i    (result),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_o       (out_o),
    .busy_o      (out_busy)
  );

  `SQLM_ASSERT_IMP(a_drop_zero, clk_i, rst_ni, out_valid_o && !out_o.out_keep, out_o.out_byte == 8'h00)
  `SQLM_ASSERT_NXT(a_adv_valid, clk_i, rst_ni, advance, out_valid_o)
  `SQLM_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i && in_valid_q)

endmodule

[rtl/sqlm_in_stage.sv]
module sqlm_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  sqlm_pkg::in_t in_i,
  input  logic          advance_i,
  output logic          valid_o,
  output sqlm_pkg::in_t data_o
);

  logic          valid_q, valid_d;
  sqlm_pkg::in_t data_q;
  logic          take;

  // Refill whenever the held transaction leaves or the stage is empty.
  assign in_stall_o = valid_q && !advance_i;
  assign take       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      data_q <= in_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[rtl/sqlm_scan.sv]
module sqlm_scan (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           advance_i,
  input  sqlm_pkg::in_t  item_i,
  output sqlm_pkg::out_t result_o
);

  sqlm_pkg::region_e region_q, region_d;
  logic              dq_q, dq_d;
  logic              esc_q, esc_d;

  logic [7:0] b;
  logic [7:0] delim;
  logic       is_quote;
  logic       go_outside;
  logic       esc_eff;

  assign b        = item_i.in_byte;
  assign delim    = dq_q ? sqlm_pkg::CH_DQUOTE : sqlm_pkg::CH_SQUOTE;
  assign is_quote = (b == sqlm_pkg::CH_SQUOTE) || (b == sqlm_pkg::CH_DQUOTE);

  // Decide whether this byte is handled as text outside a literal.
  always_comb begin
    go_outside = 1'b0;
    esc_eff    = esc_q;
    unique case (region_q)
      sqlm_pkg::REGION_IN: begin
        go_outside = 1'b0;
      end
      sqlm_pkg::REGION_CLOSING: begin
        go_outside = (b != delim);
        esc_eff    = 1'b0;
      end
      default: begin
        go_outside = 1'b1;
      end
    endcase
  end

  // Next state.
  always_comb begin
    region_d = region_q;
    dq_d     = dq_q;
    esc_d    = esc_q;
    if (go_outside) begin
      if (!esc_eff && is_quote) begin
        region_d = sqlm_pkg::REGION_IN;
        dq_d     = (b == sqlm_pkg::CH_DQUOTE);
        esc_d    = 1'b0;
      end else begin
        region_d = sqlm_pkg::REGION_OUT;
        esc_d    = !esc_eff && (b == sqlm_pkg::CH_BSLASH);
      end
    end else if (region_q == sqlm_pkg::REGION_CLOSING) begin
      // Doubled delimiter: stay inside the literal.
      region_d = sqlm_pkg::REGION_IN;
    end else if (esc_q) begin
      esc_d = 1'b0;
    end else if (b == sqlm_pkg::CH_BSLASH) begin
      esc_d = 1'b1;
    end else if (b == delim) begin
      region_d = sqlm_pkg::REGION_CLOSING;
    end
    if (item_i.in_last) begin
      region_d = sqlm_pkg::REGION_OUT;
      dq_d     = 1'b0;
      esc_d    = 1'b0;
    end
  end

  // Result.
  always_comb begin
    result_o.out_byte = 8'h00;
    result_o.out_keep = 1'b0;
    result_o.out_last = item_i.in_last;
    if (go_outside) begin
      result_o.out_keep = 1'b1;
      result_o.out_byte = (!esc_eff && is_quote) ? sqlm_pkg::CH_MASK : b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_q <= sqlm_pkg::REGION_OUT;
      dq_q     <= 1'b0;
      esc_q    <= 1'b0;
    end else if (advance_i) begin
      region_q <= region_d;
      dq_q     <= dq_d;
      esc_q    <= esc_d;
    end
  end

endmodule

[rtl/sqlm_out_stage.sv]
module sqlm_out_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  sqlm_pkg::out_t result_i,
  input  logic           out_stall_i,
  output logic           out_valid_o,
  output sqlm_pkg::out_t out_o,
  output logic           busy_o
);

  logic           valid_q, valid_d;
  sqlm_pkg::out_t data_q;

  // Busy while a result waits and the receiver holds it back.
  assign busy_o = valid_q && out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;

endmodule
